[hw/rtl/cmpt_pkg.sv]
package cmpt_pkg;

	// number of vectoring iterations, 8 to 24
	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_IW      = 5;

	// rotation datapath: phase operands reach about 2^48 after gain growth
	localparam int XW = 52;
	// angle accumulator, 2^32 per turn plus headroom
	localparam int AW = 34;

	localparam logic signed [AW-1:0] HALF_TURN = 34'sd2147483648;
	localparam logic [31:0]          GAIN_FIX  = 32'd2608131496;
	localparam logic signed [31:0]   VAL_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0]   VAL_MIN   = 32'sh80000000;

	typedef struct packed {
		logic              cap;
		logic              mul0;
		logic              mul1;
		logic              load;
		logic              iter;
		logic [ITER_W-1:0] idx;
		logic              post;
		logic              finish;
	} cmpt_cmd_t;

	typedef struct packed {
		logic phase_mode;
	} cmpt_sts_t;

	// atan(2^-i) with 2^32 per turn
	function automatic logic signed [AW-1:0] cmpt_atan(input logic [ATAN_IW-1:0] i);
		logic signed [AW-1:0] r;
		case (i)
			5'd0:    r = 34'sd536870912;
			5'd1:    r = 34'sd316933406;
			5'd2:    r = 34'sd167458907;
			5'd3:    r = 34'sd85004756;
			5'd4:    r = 34'sd42667331;
			5'd5:    r = 34'sd21354465;
			5'd6:    r = 34'sd10679838;
			5'd7:    r = 34'sd5340245;
			5'd8:    r = 34'sd2670163;
			5'd9:    r = 34'sd1335087;
			5'd10:   r = 34'sd667544;
			5'd11:   r = 34'sd333772;
			5'd12:   r = 34'sd166886;
			5'd13:   r = 34'sd83443;
			5'd14:   r = 34'sd41722;
			5'd15:   r = 34'sd20861;
			5'd16:   r = 34'sd10430;
			5'd17:   r = 34'sd5215;
			5'd18:   r = 34'sd2608;
			5'd19:   r = 34'sd1304;
			5'd20:   r = 34'sd652;
			5'd21:   r = 34'sd326;
			5'd22:   r = 34'sd163;
			5'd23:   r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/cmpt_ctrl.sv]
module cmpt_ctrl import cmpt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  cmpt_sts_t sts,
	output cmpt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL0   = 3'd1;
	localparam logic [2:0] S_MUL1   = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_ITER   = 3'd4;
	localparam logic [2:0] S_POST   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	localparam logic [ITER_W-1:0] IT_LAST = ITER_W'(CORDIC_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [ITER_W-1:0] it_q;
	logic              out_valid_q;
	logic              in_acc;
	logic              out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		cmd.idx    = it_q;
		cmd.cap    = in_acc;
		cmd.mul0   = (state_q == S_MUL0);
		cmd.mul1   = (state_q == S_MUL1);
		cmd.load   = (state_q == S_LOAD);
		cmd.iter   = (state_q == S_ITER);
		cmd.post   = (state_q == S_POST);
		cmd.finish = (state_q == S_FINISH) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc)
					state_d = sts.phase_mode ? S_MUL0 : S_LOAD;
			end
			S_MUL0:   state_d = S_MUL1;
			S_MUL1:   state_d = S_LOAD;
			S_LOAD:   state_d = S_ITER;
			S_ITER: begin
				if (it_q == IT_LAST)
					state_d = S_POST;
			end
			S_POST:   state_d = S_FINISH;
			S_FINISH: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOAD)
				it_q <= '0;
			else if (state_q == S_ITER)
				it_q <= it_q + 1'b1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_MUL0 || state_q == S_LOAD))
		else $error("accepted beat did not start processing");

	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && it_q == IT_LAST) |=> state_q == S_POST)
		else $error("rotation did not end after last step");

	a_mul_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL0 || state_q == S_MUL1) |-> sts.phase_mode)
		else $error("product stage entered in amplitude mode");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && out_stall)
		|=> (state_q == S_FINISH && out_valid_q))
		else $error("result overwrote a held beat");

endmodule

[hw/rtl/cmpt_datapath.sv]
module cmpt_datapath import cmpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	input  logic               row_last,
	input  logic               frame_last,
	input  cmpt_cmd_t          cmd,
	output cmpt_sts_t          sts,
	output logic signed [31:0] out_value,
	output logic signed [31:0] running_min,
	output logic signed [31:0] running_max
);

	logic               phase_mode_q;
	logic signed [15:0] prev_re_q, prev_im_q;
	logic signed [31:0] acc_q, min_q, max_q;

	logic signed [15:0] re_q, im_q;
	logic               row_q, frame_q;
	logic signed [32:0] pr_q, pi_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [AW-1:0] a_q;
	logic [63:0]        gain_q;
	logic signed [31:0] sat_q;
	logic signed [31:0] val_q, omin_q, omax_q;

	logic               zero_in;
	logic signed [15:0] op_a, op_b, op_c, op_d;
	logic signed [31:0] m1, m2;
	logic signed [32:0] msum;
	logic signed [XW-1:0] x_init, y_init, dx, dy;
	logic signed [AW-1:0] atan_i;
	logic [31:0]        ux;
	logic signed [AW-1:0] a_rnd;
	logic signed [17:0] delta;
	logic signed [34:0] sum;
	logic [63:0]        rnd;
	logic signed [31:0] val;
	logic signed [31:0] new_min, new_max;

	assign sts.phase_mode = phase_mode_q;

	// a zero sample counts as real one for the phase only
	assign zero_in = phase_mode_q && (sample_re == 16'sd0) && (sample_im == 16'sd0);

	// shared pair of multipliers for the two conjugate product terms
	assign op_a = cmd.mul0 ? re_q : im_q;
	assign op_b = prev_re_q;
	assign op_c = cmd.mul0 ? im_q : prev_im_q;
	assign op_d = cmd.mul0 ? prev_im_q : re_q;
	assign m1   = op_a * op_b;
	assign m2   = op_c * op_d;
	assign msum = cmd.mul0 ? (33'(m1) + 33'(m2)) : (33'(m1) - 33'(m2));

	always_comb begin
		if (phase_mode_q) begin
			x_init = $signed({{(XW-49){pr_q[32]}}, pr_q, 16'b0});
			y_init = $signed({{(XW-49){pi_q[32]}}, pi_q, 16'b0});
		end else begin
			x_init = $signed({{(XW-30){re_q[15]}}, re_q, 14'b0});
			y_init = $signed({{(XW-30){im_q[15]}}, im_q, 14'b0});
		end
	end

	assign dx     = y_q >>> cmd.idx;
	assign dy     = x_q >>> cmd.idx;
	assign atan_i = cmpt_atan(ATAN_IW'(cmd.idx));

	assign ux    = (!x_q[XW-1] && x_q != '0) ? x_q[31:0] : 32'd0;
	assign a_rnd = a_q + AW'(32768);
	assign delta = a_rnd[AW-1:16];
	assign sum   = 35'(acc_q) + 35'(delta);

	assign rnd     = gain_q + (64'd1 << 45);
	assign val     = phase_mode_q ? sat_q : $signed(rnd[63:46] & 18'h3ffff) ;
	assign new_max = (val > max_q) ? val : max_q;
	assign new_min = (val < min_q) ? val : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_mode_q <= 1'b0;
			prev_re_q    <= 16'sd1;
			prev_im_q    <= 16'sd0;
			acc_q        <= 32'sd0;
			min_q        <= VAL_MAX;
			max_q        <= VAL_MIN;
		end else begin
			if (cfg_wr_en)
				phase_mode_q <= cfg_wr_data;
			if (cmd.finish) begin
				if (row_q || frame_q) begin
					acc_q     <= 32'sd0;
					prev_re_q <= 16'sd1;
					prev_im_q <= 16'sd0;
				end else if (phase_mode_q) begin
					acc_q     <= sat_q;
					prev_re_q <= re_q;
					prev_im_q <= im_q;
				end
				if (frame_q) begin
					min_q <= VAL_MAX;
					max_q <= VAL_MIN;
				end else begin
					min_q <= new_min;
					max_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			re_q    <= zero_in ? 16'sd1 : sample_re;
			im_q    <= sample_im;
			row_q   <= row_last;
			frame_q <= frame_last;
		end
		if (cmd.mul0)
			pr_q <= msum;
		if (cmd.mul1)
			pi_q <= msum;
		if (cmd.load) begin
			// left half plane: turn by a half turn first
			if (x_init[XW-1]) begin
				x_q <= -x_init;
				y_q <= -y_init;
				a_q <= y_init[XW-1] ? -HALF_TURN : HALF_TURN;
			end else begin
				x_q <= x_init;
				y_q <= y_init;
				a_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				a_q <= a_q + atan_i;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				a_q <= a_q - atan_i;
			end
		end
		if (cmd.post) begin
			gain_q <= 64'(ux) * 64'(GAIN_FIX);
			if (sum > 35'(VAL_MAX))
				sat_q <= VAL_MAX;
			else if (sum < 35'(VAL_MIN))
				sat_q <= VAL_MIN;
			else
				sat_q <= sum[31:0];
		end
		if (cmd.finish) begin
			val_q  <= val;
			omin_q <= new_min;
			omax_q <= new_max;
		end
	end

	assign out_value   = val_q;
	assign running_min = omin_q;
	assign running_max = omax_q;

endmodule

[hw/rtl/complex_magnitude_phase_tracker_unit.sv]
// complex magnitude and accumulated phase tracker
// input channel: in_valid / in_stall carry one complex sample per beat with
// row_last and frame_last markers; a beat is taken when in_valid is high and
// in_stall is low. output channel: out_valid / out_stall carry out_value with
// the running minimum and maximum of the current frame.
// phase_mode is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the unit is idle; the unit does not enforce this. 0
// gives the magnitude, 1 the saturated per-row accumulated phase (65536 per
// turn) of each sample against the previous one. each sample runs through
// one shared vectoring rotator, one step a cycle; in phase mode the two
// product terms are formed before it. the next sample can be taken in the
// cycle after the result is registered, not while one is still in flight.
// a finished result waits in the output register while a new sample is taken;
// if out_stall still holds the previous beat when the next result is ready,
// the unit waits in its last step until the beat is taken.
// reset clears phase_mode, the row state (previous sample real one, zero
// accumulator) and the frame minimum and maximum; no result is pending.
module complex_magnitude_phase_tracker_unit import cmpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	input  logic               row_last,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_value,
	output logic signed [31:0] running_min,
	output logic signed [31:0] running_max
);

	cmpt_cmd_t cmd;
	cmpt_sts_t sts;

	cmpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cmpt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.row_last    (row_last),
		.frame_last  (frame_last),
		.cmd         (cmd),
		.sts         (sts),
		.out_value   (out_value),
		.running_min (running_min),
		.running_max (running_max)
	);

endmodule
